// File: hdl/cls_pkg.sv
`timescale 1ns / 1ps
// Shared constants, entry layout and controller/datapath interface types of the sequencer.
package cls_pkg;

   localparam int PROGRAM_DEPTH = 64;
   localparam int LABEL_BITS    = 8;
   localparam int POS_W         = $clog2(PROGRAM_DEPTH);
   localparam int CNT_W         = $clog2(PROGRAM_DEPTH + 1);

   localparam int OP_W       = 3;
   localparam int KIND_W     = 3;
   localparam int TYPE_W     = 4;
   localparam int MOD_W      = 3;
   localparam int TOTAL_W    = 16;
   localparam int LABEL_W    = 8;
   localparam int POSITION_W = 6;
   localparam int LENGTH_W   = 7;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = OP_W + KIND_W;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 4;

   localparam logic [OP_W-1:0] OP_BEGIN   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_ADVANCE = 3'd4;

   localparam logic [KIND_W-1:0] KIND_SIMPLE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MODIFIED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_JUMP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LABEL    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [TYPE_W-1:0]     ctype;
      logic [MOD_W-1:0]      modifier;
      logic [TOTAL_W-1:0]    total;
      logic [LABEL_BITS-1:0] label;
   } entry_type;

   typedef enum logic [1:0] {
      POS_KEEP,
      POS_ZERO,
      POS_NEXT,
      POS_HIT
   } pos_sel_type;

   typedef enum logic [2:0] {
      REP_KEEP,
      REP_ZERO,
      REP_COUNT,
      REP_BASE,
      REP_BASE_DEC
   } rep_sel_type;

   typedef struct packed {
      logic        fault_clr;
      logic        fault_set;
      logic        cnt_zero;
      logic        cnt_inc;
      logic        mem_we;
      pos_sel_type pos_sel;
      rep_sel_type rep_sel;
      logic        rd_scan;
      logic        scan_load_zero;
      logic        scan_load_next;
      logic        scan_step;
      logic        tgt_load;
      logic        out_load;
   } cls_cmd_type;

   typedef struct packed {
      logic              cnt_zero;
      logic              cnt_full;
      logic              pos_oor;
      logic [KIND_W-1:0] rd_kind;
      logic              label_match;
      logic              base_zero;
      logic              scan_last;
      logic              out_free;
   } cls_status_type;

   // Repeat load value of an entry: extra runs of a repeat entry, zero otherwise.
   function automatic logic [TOTAL_W-1:0] count_of(entry_type e);
      logic [TOTAL_W-1:0] res;
      res = '0;
      if (e.kind == KIND_REPEAT && e.total != '0) begin
         res = e.total - TOTAL_W'(1);
      end
      return res;
   endfunction

endpackage

// File: hdl/cls_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences each request through reads, scans and the result load.
module cls_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [cls_pkg::OP_W-1:0]   req_op,
   input  cls_pkg::cls_status_type    status,
   output cls_pkg::cls_cmd_type       cmd
);
   import cls_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_USE,
      ST_ADV_RD,
      ST_ADV_USE,
      ST_SKIP_RD,
      ST_SKIP_USE,
      ST_SCAN_RD,
      ST_SCAN_USE,
      ST_FETCH,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      jump_mode_ff, jump_mode_in;
   logic      moved_ff, moved_in;
   logic      scan_hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign scan_hit   = jump_mode_ff ? status.label_match : (status.rd_kind != KIND_LABEL);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      jump_mode_in = jump_mode_ff;
      moved_in     = moved_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.fault_clr = 1'b1;
               state_in      = ST_FETCH;
               case (req_op)
                  OP_BEGIN: begin
                     cmd.cnt_zero = 1'b1;
                  end
                  OP_APPEND: begin
                     if (status.cnt_full) begin
                        cmd.fault_set = 1'b1;
                     end else begin
                        cmd.mem_we  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     if (!status.cnt_zero) begin
                        if (status.pos_oor) begin
                           cmd.pos_sel   = POS_ZERO;
                           cmd.fault_set = 1'b1;
                        end
                        state_in = ST_LOAD_RD;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.pos_sel  = POS_ZERO;
                     cmd.rep_sel  = REP_ZERO;
                     cmd.cnt_zero = 1'b1;
                  end
                  OP_ADVANCE: begin
                     if (!status.cnt_zero) begin
                        if (status.pos_oor) begin
                           cmd.pos_sel   = POS_ZERO;
                           cmd.fault_set = 1'b1;
                        end
                        state_in = ST_ADV_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD_USE;
         end
         ST_LOAD_USE: begin
            cmd.rep_sel = REP_COUNT;
            state_in    = ST_DONE;
         end
         ST_ADV_RD: begin
            state_in = ST_ADV_USE;
         end
         ST_ADV_USE: begin
            moved_in = 1'b0;
            state_in = ST_SKIP_RD;
            case (status.rd_kind)
               KIND_JUMP: begin
                  cmd.rep_sel        = REP_BASE;
                  cmd.tgt_load       = 1'b1;
                  cmd.scan_load_zero = 1'b1;
                  jump_mode_in       = 1'b1;
                  state_in           = ST_SCAN_RD;
               end
               KIND_REPEAT: begin
                  if (status.base_zero) begin
                     cmd.pos_sel = POS_NEXT;
                     moved_in    = 1'b1;
                  end else begin
                     cmd.rep_sel = REP_BASE_DEC;
                  end
               end
               KIND_SIMPLE, KIND_MODIFIED: begin
                  cmd.pos_sel = POS_NEXT;
                  moved_in    = 1'b1;
               end
               default: begin
                  cmd.rep_sel = REP_BASE;
               end
            endcase
         end
         ST_SKIP_RD: begin
            state_in = ST_SKIP_USE;
         end
         ST_SKIP_USE: begin
            if (moved_ff) begin
               cmd.rep_sel = REP_COUNT;
            end
            if (status.rd_kind == KIND_LABEL) begin
               cmd.scan_load_next = 1'b1;
               jump_mode_in       = 1'b0;
               state_in           = ST_SCAN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            cmd.rd_scan   = 1'b1;
            cmd.scan_step = 1'b1;
            state_in      = ST_SCAN_USE;
         end
         ST_SCAN_USE: begin
            cmd.rd_scan = 1'b1;
            if (scan_hit) begin
               cmd.pos_sel = POS_HIT;
               if (jump_mode_ff) begin
                  moved_in = 1'b1;
                  state_in = ST_SKIP_RD;
               end else begin
                  cmd.rep_sel = REP_COUNT;
                  state_in    = ST_FETCH;
               end
            end else if (status.scan_last) begin
               cmd.fault_set = 1'b1;
               moved_in      = 1'b0;
               state_in      = jump_mode_ff ? ST_SKIP_RD : ST_FETCH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         jump_mode_ff <= 1'b0;
         moved_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         jump_mode_ff <= jump_mode_in;
         moved_ff     <= moved_in;
      end
   end

endmodule

// File: hdl/cls_datapath.sv
`timescale 1ns / 1ps
// Datapath: program memory, position, count and repeat registers, scan logic and result register.
module cls_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cls_pkg::cls_cmd_type          cmd,
   output cls_pkg::cls_status_type       status,
   input  logic [cls_pkg::KIND_W-1:0]    req_kind,
   input  logic [cls_pkg::TYPE_W-1:0]    req_cmd_type,
   input  logic [cls_pkg::MOD_W-1:0]     req_modifier,
   input  logic [cls_pkg::TOTAL_W-1:0]   req_repeat_total,
   input  logic [cls_pkg::LABEL_W-1:0]   req_label_id,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [cls_pkg::POSITION_W-1:0] rsp_position,
   output logic [cls_pkg::LENGTH_W-1:0]  rsp_length,
   output logic [cls_pkg::TYPE_W-1:0]    rsp_cur_type,
   output logic [cls_pkg::MOD_W-1:0]     rsp_cur_modifier,
   output logic [cls_pkg::TOTAL_W-1:0]   rsp_repeats_left,
   output logic                          rsp_is_repeat,
   output logic                          rsp_is_empty,
   output logic                          rsp_bad_current,
   output logic                          rsp_fault
);
   import cls_pkg::*;

   entry_type             mem [PROGRAM_DEPTH];
   entry_type             mem_q_ff;
   logic [POS_W-1:0]      rd_idx_ff;
   logic [POS_W-1:0]      rd_addr;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]    rep_ff, rep_in;
   logic                  fault_ff, fault_in;
   logic [POS_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [LABEL_BITS-1:0] tgt_ff, tgt_in;
   logic                  rsp_valid_ff;

   entry_type             new_entry;
   logic [POS_W-1:0]      pos_next;
   logic [POS_W-1:0]      scan_next;
   logic [TOTAL_W-1:0]    base;
   logic                  cur_valid;
   logic [KIND_W-1:0]     cur_kind;

   // Saturate unknown kinds to error and keep only the matching label bits.
   always_comb begin
      new_entry.kind     = (req_kind > KIND_ERROR) ? KIND_ERROR : req_kind;
      new_entry.ctype    = req_cmd_type;
      new_entry.modifier = req_modifier;
      new_entry.total    = req_repeat_total;
      new_entry.label    = req_label_id[LABEL_BITS-1:0];
   end

   assign rd_addr   = cmd.rd_scan ? scan_ff : pos_ff;
   assign pos_next  = (CNT_W'(pos_ff) + CNT_W'(1) == cnt_ff) ? '0 : pos_ff + POS_W'(1);
   assign scan_next = (CNT_W'(scan_ff) + CNT_W'(1) == cnt_ff) ? '0 : scan_ff + POS_W'(1);
   // Right after a range fix the counter must come from entry zero.
   assign base      = fault_ff ? count_of(mem_q_ff) : rep_ff;

   always_comb begin
      status.cnt_zero    = (cnt_ff == '0);
      status.cnt_full    = (cnt_ff == CNT_W'(PROGRAM_DEPTH));
      status.pos_oor     = (CNT_W'(pos_ff) >= cnt_ff);
      status.rd_kind     = mem_q_ff.kind;
      status.label_match = (mem_q_ff.kind == KIND_LABEL) && (mem_q_ff.label == tgt_ff);
      status.base_zero   = (base == '0);
      status.scan_last   = (n_ff == cnt_ff);
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      case (cmd.pos_sel)
         POS_KEEP: pos_in = pos_ff;
         POS_ZERO: pos_in = '0;
         POS_NEXT: pos_in = pos_next;
         POS_HIT:  pos_in = rd_idx_ff;
         default:  pos_in = pos_ff;
      endcase
      case (cmd.rep_sel)
         REP_KEEP:     rep_in = rep_ff;
         REP_ZERO:     rep_in = '0;
         REP_COUNT:    rep_in = count_of(mem_q_ff);
         REP_BASE:     rep_in = base;
         REP_BASE_DEC: rep_in = base - TOTAL_W'(1);
         default:      rep_in = rep_ff;
      endcase
      cnt_in = cnt_ff;
      if (cmd.cnt_zero) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      fault_in = fault_ff;
      if (cmd.fault_set) begin
         fault_in = 1'b1;
      end else if (cmd.fault_clr) begin
         fault_in = 1'b0;
      end
      scan_in = scan_ff;
      n_in    = n_ff;
      if (cmd.scan_load_zero) begin
         scan_in = '0;
         n_in    = '0;
      end else if (cmd.scan_load_next) begin
         scan_in = pos_next;
         n_in    = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_next;
         n_in    = n_ff + CNT_W'(1);
      end
      tgt_in = cmd.tgt_load ? mem_q_ff.label : tgt_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[cnt_ff[POS_W-1:0]] <= new_entry;
      end
      mem_q_ff  <= mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rep_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         rep_ff   <= rep_in;
         fault_ff <= fault_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      n_ff    <= n_in;
      tgt_ff  <= tgt_in;
   end

   assign cur_valid = !status.cnt_zero && !status.pos_oor;
   assign cur_kind  = mem_q_ff.kind;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_position     <= POSITION_W'(pos_ff);
         rsp_length       <= LENGTH_W'(cnt_ff);
         rsp_cur_type     <= (cur_valid && (cur_kind inside {KIND_SIMPLE, KIND_MODIFIED,
                              KIND_REPEAT})) ? mem_q_ff.ctype : '0;
         rsp_cur_modifier <= (cur_valid && (cur_kind inside {KIND_MODIFIED, KIND_REPEAT}))
                              ? mem_q_ff.modifier : '0;
         rsp_repeats_left <= rep_ff;
         rsp_is_repeat    <= cur_valid && (cur_kind == KIND_REPEAT);
         rsp_is_empty     <= status.cnt_zero;
         rsp_bad_current  <= !cur_valid || (cur_kind == KIND_ERROR);
         rsp_fault        <= fault_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(PROGRAM_DEPTH))
      else $error("entry count beyond program depth");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("append did not count up the entry count");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_sel == POS_HIT |-> CNT_W'(rd_idx_ff) < cnt_ff)
      else $error("scan hit outside the loaded program");
`endif

endmodule

// File: hdl/command_list_sequencer.sv
`timescale 1ns / 1ps
// Top level of the command list sequencer: stream ports, field packing, controller and datapath.
//
// Usage: every request on the req_ stream carries an op (begin load, append, finish load,
// clear, advance) and, for append, one program entry. Each request yields exactly one
// response on the rsp_ stream describing the current entry after the op: position,
// length, type, modifier, repeats left and the repeat/empty/bad/fault flags.
// Finish load on a loaded program reads the current entry to load the repeat counter;
// advance reads the current entry and may run a jump-target scan and a label-skip scan.
// A scan reads at most PROGRAM_DEPTH entries, one per cycle through the single read port
// of the program memory, and the two scans of one advance read at most 2*PROGRAM_DEPTH - 1
// entries together. One request is in work at a time; req_tready is high only while the
// sequencer is idle.
// Stall: the response sits in an output register; the next request is accepted while it
// waits, but that request's response holds until rsp_tready drains the register.
// Reset: synchronous, active high; position, entry count and repeat counter go to zero,
// no response is pending. The program memory is not cleared; only loaded entries are read.
module command_list_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cmd_type[3:0], modifier[6:4], repeat_total[22:7], label_id[30:23], zero pad
   input  logic [cls_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[2:0], kind[5:3]
   input  logic [cls_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // position[5:0], length[12:6], cur_type[16:13], cur_modifier[19:17],
   // repeats_left[35:20], zero pad
   output logic [cls_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_repeat[0], is_empty[1], bad_current[2], fault[3]
   output logic [cls_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import cls_pkg::*;

   cls_cmd_type            cmd;
   cls_status_type         status;

   // Unpacked request fields.
   logic [OP_W-1:0]        req_op;
   logic [KIND_W-1:0]      req_kind;
   logic [TYPE_W-1:0]      req_cmd_type;
   logic [MOD_W-1:0]       req_modifier;
   logic [TOTAL_W-1:0]     req_repeat_total;
   logic [LABEL_W-1:0]     req_label_id;

   // Response fields from the datapath's output register.
   logic [POSITION_W-1:0]  rsp_position;
   logic [LENGTH_W-1:0]    rsp_length;
   logic [TYPE_W-1:0]      rsp_cur_type;
   logic [MOD_W-1:0]       rsp_cur_modifier;
   logic [TOTAL_W-1:0]     rsp_repeats_left;
   logic                   rsp_is_repeat;
   logic                   rsp_is_empty;
   logic                   rsp_bad_current;
   logic                   rsp_fault;

   // Split the request: op and kind ride in tuser, the rest in tdata from bit 0 up.
   assign req_op           = req_tuser[OP_W-1:0];
   assign req_kind         = req_tuser[OP_W +: KIND_W];
   assign req_cmd_type     = req_tdata[0 +: TYPE_W];
   assign req_modifier     = req_tdata[TYPE_W +: MOD_W];
   assign req_repeat_total = req_tdata[TYPE_W + MOD_W +: TOTAL_W];
   assign req_label_id     = req_tdata[TYPE_W + MOD_W + TOTAL_W +: LABEL_W];

   // Sequence each request: decode the op, drive reads and scans, load the response.
   cls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the program and the sequencer state; build the response.
   cls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_cmd_type     (req_cmd_type),
      .req_modifier     (req_modifier),
      .req_repeat_total (req_repeat_total),
      .req_label_id     (req_label_id),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_position     (rsp_position),
      .rsp_length       (rsp_length),
      .rsp_cur_type     (rsp_cur_type),
      .rsp_cur_modifier (rsp_cur_modifier),
      .rsp_repeats_left (rsp_repeats_left),
      .rsp_is_repeat    (rsp_is_repeat),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_bad_current  (rsp_bad_current),
      .rsp_fault        (rsp_fault)
   );

   // Pack the response, first field lowest, zero pad to whole bytes.
   assign rsp_tdata = RSP_DATA_W'({rsp_repeats_left, rsp_cur_modifier, rsp_cur_type,
                                   rsp_length, rsp_position});
   assign rsp_tuser = {rsp_fault, rsp_bad_current, rsp_is_empty, rsp_is_repeat};

endmodule
